[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the mirror header rewrite unit.
// Each macro places one labeled concurrent assertion, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/gmhr_pkg.sv]
// Types and constants of the mirror header rewrite unit.
// Used by gmhr_hold_bank, gmhr_fifo and gre_mirror_header_rewrite_unit.
`default_nettype none

package gmhr_pkg;

    localparam int IPV4_HDR_BYTES = 20;
    localparam int IPV6_HDR_BYTES = 40;
    localparam int HOLD_IDX_W = $clog2(IPV4_HDR_BYTES);
    localparam int POS_W = 6;

    localparam logic [3:0] VER_IPV4 = 4'd4;
    localparam logic [3:0] VER_IPV6 = 4'd6;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_V6_HOP = POS_W'(7);
    localparam logic [POS_W-1:0] POS_V6_GRE_HI = POS_W'(IPV6_HDR_BYTES + 2);
    localparam logic [POS_W-1:0] POS_V6_GRE_LO = POS_W'(IPV6_HDR_BYTES + 3);
    localparam logic [POS_W-1:0] POS_V4_TTL = POS_W'(8);
    localparam logic [POS_W-1:0] POS_V4_CHK_HI = POS_W'(10);
    localparam logic [POS_W-1:0] POS_V4_CHK_LO = POS_W'(11);
    localparam logic [POS_W-1:0] POS_V4_HDR_END = POS_W'(IPV4_HDR_BYTES);
    localparam logic [POS_W-1:0] POS_V4_HDR_LAST = POS_W'(IPV4_HDR_BYTES - 1);
    localparam logic [POS_W-1:0] POS_V4_GRE_HI = POS_W'(IPV4_HDR_BYTES + 2);
    localparam logic [POS_W-1:0] POS_V4_GRE_LO = POS_W'(IPV4_HDR_BYTES + 3);

    localparam logic [HOLD_IDX_W-1:0] IDX_TTL = HOLD_IDX_W'(8);
    localparam logic [HOLD_IDX_W-1:0] IDX_CHK_HI = HOLD_IDX_W'(10);
    localparam logic [HOLD_IDX_W-1:0] IDX_CHK_LO = HOLD_IDX_W'(11);
    localparam logic [HOLD_IDX_W-1:0] IDX_LAST = HOLD_IDX_W'(IPV4_HDR_BYTES - 1);

    typedef enum logic [1:0] {
        CLS_NOCFG = 2'd0,
        CLS_NOTIP = 2'd1,
        CLS_V4    = 2'd2,
        CLS_V6    = 2'd3
    } pkt_class_t;

    typedef enum logic [1:0] {
        ST_REWRITTEN = 2'd0,
        ST_NOT_IP    = 2'd1,
        ST_NO_CFG    = 2'd2
    } fix_status_t;

    typedef enum logic [1:0] {
        CFG_TUNNEL_INDEX   = 2'd0,
        CFG_TUNNEL_ENABLED = 2'd1,
        CFG_OUTER_TTL      = 2'd2,
        CFG_GRE_PROTO      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       local_origin;
        logic [1:0] fix_status;
    } out_item_t;

    typedef struct packed {
        logic      is_burst;
        logic      bank;
        out_item_t item;
    } queue_token_t;

    typedef struct packed {
        logic                  full_hdr;
        logic                  last_flag;
        logic [HOLD_IDX_W-1:0] last_idx;
        logic [7:0]            ttl;
        logic [19:0]           sum;
    } bank_info_t;

endpackage

`default_nettype wire

[hdl/gre_mirror_header_rewrite_unit.sv]
// Mirror tunnel outer header rewrite: TTL or hop limit, GRE protocol, IPv4 checksum.
// Depends on gmhr_pkg, gmhr_hold_bank, gmhr_fifo and assert_macros.svh.
//
// Packet bytes enter one per cycle and leave one per cycle. For an IPv4 packet on the
// enabled tunnel, header bytes 0 to 19 are held in one of two header buffers and are
// released as a burst of 20 bytes, or as the bytes received if the packet ends early.
// All other bytes go straight into a 32-entry result queue behind any pending burst.
// The input stalls only when that queue is full or when the next header buffer has
// not yet been drained, so the sustained rate is one byte per cycle when the output
// keeps up. A released byte is held in the output register. No clearing pass runs
// after reset.
`default_nettype none
`include "assert_macros.svh"

module gre_mirror_header_rewrite_unit import gmhr_pkg::*; #(
    parameter int FIFO_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [11:0] if_index, [19:12] data_byte, zero pad
    input  wire logic        s_tuser,   // [0] first_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [2:0]       m_tuser,   // [0] local_origin, [2:1] fix_status
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [11:0] tunnel_index_reg;
    logic        tunnel_enabled_reg;
    logic [7:0]  outer_ttl_reg;
    logic [15:0] gre_proto_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    pkt_class_t       class_reg, class_next;
    logic [19:0]      sum_reg, sum_next;
    logic             wbank_reg;
    logic [1:0]       bank_busy_reg, bank_busy_next;
    logic             drain_active_reg;
    logic             drain_bank_reg;
    logic [HOLD_IDX_W-1:0] drain_idx_reg;
    logic             m_tvalid_reg;
    out_item_t        m_item_reg;

    logic [11:0]      in_if;
    logic [7:0]       in_byte;
    logic             in_fire;
    logic             start;
    pkt_class_t       cls_new;
    logic [POS_W-1:0] eff_pos;
    logic             hold_wr;
    logic             flush_full;
    logic             flush_short;
    logic             bank_flush;
    logic [7:0]       w_byte;
    logic [19:0]      sum_add;
    logic [19:0]      sum_base;
    bank_info_t       flush_info;
    out_item_t        pass_item;
    logic             pass_last;

    logic             fifo_push;
    logic             fifo_pop;
    queue_token_t     push_token;
    queue_token_t     head_token;
    logic             fifo_empty;
    logic             fifo_full;

    logic             out_load;
    logic             have_item;
    logic             src_burst;
    logic             rd_bank;
    logic [HOLD_IDX_W-1:0] rd_idx;
    out_item_t        bank_item [2];
    logic [1:0]       bank_end;
    out_item_t        sel_item;
    logic             burst_end;

    assign in_if = s_tdata[11:0];
    assign in_byte = s_tdata[19:12];
    assign cfg_ready = 1'b1;
    assign s_tready = !fifo_full && !bank_busy_reg[wbank_reg];
    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tunnel_index_reg <= '0;
            tunnel_enabled_reg <= 1'b0;
            outer_ttl_reg <= '0;
            gre_proto_reg <= 16'h88BE;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_TUNNEL_INDEX: tunnel_index_reg <= cfg_data[11:0];
                CFG_TUNNEL_ENABLED: tunnel_enabled_reg <= cfg_data[0];
                CFG_OUTER_TTL: outer_ttl_reg <= cfg_data[7:0];
                CFG_GRE_PROTO: gre_proto_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        start = s_tuser || (pos_reg == '0);
        if (!tunnel_enabled_reg || in_if != tunnel_index_reg) begin
            cls_new = CLS_NOCFG;
        end else if (in_byte[7:4] == VER_IPV4) begin
            cls_new = CLS_V4;
        end else if (in_byte[7:4] == VER_IPV6) begin
            cls_new = CLS_V6;
        end else begin
            cls_new = CLS_NOTIP;
        end
        class_next = start ? cls_new : class_reg;
        eff_pos = start ? '0 : pos_reg;
        sum_base = start ? '0 : sum_reg;

        hold_wr = (class_next == CLS_V4) && (eff_pos < POS_V4_HDR_END);
        flush_full = hold_wr && (eff_pos == POS_V4_HDR_LAST);
        flush_short = hold_wr && !flush_full && s_tlast;
        bank_flush = in_fire && (flush_full || flush_short);

        if (eff_pos == POS_V4_TTL) begin
            w_byte = outer_ttl_reg;
        end else if (eff_pos == POS_V4_CHK_HI || eff_pos == POS_V4_CHK_LO) begin
            w_byte = '0;
        end else begin
            w_byte = in_byte;
        end
        sum_add = eff_pos[0] ? 20'(w_byte) : 20'({w_byte, 8'h00});
        sum_next = hold_wr ? sum_base + sum_add : sum_base;

        if (s_tlast) begin
            pos_next = '0;
        end else if (eff_pos < POS_MAX) begin
            pos_next = eff_pos + 1'b1;
        end else begin
            pos_next = eff_pos;
        end

        flush_info.full_hdr = flush_full;
        flush_info.last_flag = flush_full ? s_tlast : 1'b1;
        flush_info.last_idx = eff_pos[HOLD_IDX_W-1:0];
        flush_info.ttl = outer_ttl_reg;
        flush_info.sum = sum_next;

        pass_last = s_tlast;
        pass_item.out_byte = in_byte;
        pass_item.out_last = pass_last;
        pass_item.local_origin = 1'b0;
        pass_item.fix_status = ST_REWRITTEN;
        case (class_next)
            CLS_NOCFG: begin
                pass_item.fix_status = pass_last ? ST_NO_CFG : ST_REWRITTEN;
            end
            CLS_NOTIP: begin
                pass_item.fix_status = pass_last ? ST_NOT_IP : ST_REWRITTEN;
            end
            CLS_V6: begin
                pass_item.local_origin = pass_last;
                if (eff_pos == POS_V6_HOP) begin
                    pass_item.out_byte = outer_ttl_reg;
                end else if (eff_pos == POS_V6_GRE_HI) begin
                    pass_item.out_byte = gre_proto_reg[15:8];
                end else if (eff_pos == POS_V6_GRE_LO) begin
                    pass_item.out_byte = gre_proto_reg[7:0];
                end
            end
            CLS_V4: begin
                pass_item.local_origin = pass_last;
                if (eff_pos == POS_V4_GRE_HI) begin
                    pass_item.out_byte = gre_proto_reg[15:8];
                end else if (eff_pos == POS_V4_GRE_LO) begin
                    pass_item.out_byte = gre_proto_reg[7:0];
                end
            end
            default: ;
        endcase

        fifo_push = in_fire && (!hold_wr || flush_full || flush_short);
        push_token.is_burst = hold_wr;
        push_token.bank = wbank_reg;
        push_token.item = pass_item;
    end

    gmhr_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(fifo_push),
        .push_token(push_token),
        .pop(fifo_pop),
        .head_token(head_token),
        .empty(fifo_empty),
        .full(fifo_full)
    );

    for (genvar b = 0; b < 2; b++) begin : g_bank
        gmhr_hold_bank u_bank (
            .aclk(aclk),
            .wr_en(in_fire && hold_wr && (wbank_reg == 1'(b))),
            .wr_addr(eff_pos[HOLD_IDX_W-1:0]),
            .wr_data(in_byte),
            .flush_en(bank_flush && (wbank_reg == 1'(b))),
            .flush_info(flush_info),
            .rd_addr(rd_idx),
            .rd_item(bank_item[b]),
            .rd_end(bank_end[b])
        );
    end

    always_comb begin
        out_load = !m_tvalid_reg || m_tready;
        have_item = drain_active_reg || !fifo_empty;
        src_burst = drain_active_reg || (!fifo_empty && head_token.is_burst);
        rd_bank = drain_active_reg ? drain_bank_reg : head_token.bank;
        rd_idx = drain_active_reg ? drain_idx_reg : '0;
        sel_item = src_burst ? bank_item[rd_bank] : head_token.item;
        burst_end = src_burst && bank_end[rd_bank];
        fifo_pop = out_load && !drain_active_reg && !fifo_empty;

        bank_busy_next = bank_busy_reg;
        if (out_load && burst_end) begin
            bank_busy_next[rd_bank] = 1'b0;
        end
        if (bank_flush) begin
            bank_busy_next[wbank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && have_item) begin
            m_item_reg <= sel_item;
        end
        if (out_load && src_burst) begin
            drain_bank_reg <= rd_bank;
            drain_idx_reg <= rd_idx + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            class_reg <= CLS_NOCFG;
            sum_reg <= '0;
            wbank_reg <= 1'b0;
            bank_busy_reg <= '0;
            drain_active_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                pos_reg <= pos_next;
                class_reg <= class_next;
                sum_reg <= sum_next;
            end
            if (bank_flush) begin
                wbank_reg <= !wbank_reg;
            end
            bank_busy_reg <= bank_busy_next;
            if (out_load) begin
                m_tvalid_reg <= have_item;
                drain_active_reg <= src_burst && !burst_end;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_item_reg.out_byte;
    assign m_tlast = m_item_reg.out_last;
    assign m_tuser = {m_item_reg.fix_status, m_item_reg.local_origin};

    `ASSERT_IMPL(a_no_queue_overflow, aclk, aresetn, fifo_push, !fifo_full)
    `ASSERT_IMPL(a_drain_busy_bank, aclk, aresetn, drain_active_reg, bank_busy_reg[drain_bank_reg])
    `ASSERT_IMPL(a_flush_into_free_bank, aclk, aresetn, bank_flush, !bank_busy_reg[wbank_reg])
    `ASSERT_NEXT(a_burst_end_frees_bank, aclk, aresetn, out_load && burst_end, !drain_active_reg)

endmodule

`default_nettype wire

[hdl/gmhr_hold_bank.sv]
// One buffer of held IPv4 header bytes with its release details.
// On readout it patches TTL and checksum of a full header and marks the end of the burst.
`default_nettype none

module gmhr_hold_bank import gmhr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [HOLD_IDX_W-1:0] wr_addr,
    input  wire logic [7:0]            wr_data,
    input  wire logic                  flush_en,
    input  wire bank_info_t            flush_info,
    input  wire logic [HOLD_IDX_W-1:0] rd_addr,
    output out_item_t                  rd_item,
    output logic                       rd_end
);

    logic [7:0] hold_reg [IPV4_HDR_BYTES];
    bank_info_t info_reg;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] chk;
    logic        item_last;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hold_reg[wr_addr] <= wr_data;
        end
        if (flush_en) begin
            info_reg <= flush_info;
        end
    end

    always_comb begin
        fold1 = {1'b0, info_reg.sum[15:0]} + 17'(info_reg.sum[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        chk = ~fold2;
        rd_end = (rd_addr == info_reg.last_idx);
        item_last = rd_end & info_reg.last_flag;
        rd_item.out_byte = hold_reg[rd_addr];
        if (info_reg.full_hdr) begin
            if (rd_addr == IDX_TTL) begin
                rd_item.out_byte = info_reg.ttl;
            end else if (rd_addr == IDX_CHK_HI) begin
                rd_item.out_byte = chk[15:8];
            end else if (rd_addr == IDX_CHK_LO) begin
                rd_item.out_byte = chk[7:0];
            end
        end
        rd_item.out_last = item_last;
        rd_item.local_origin = item_last & info_reg.full_hdr;
        rd_item.fix_status = (item_last && !info_reg.full_hdr) ? ST_NOT_IP : ST_REWRITTEN;
    end

endmodule

`default_nettype wire

[hdl/gmhr_fifo.sv]
// Result queue of the mirror header rewrite unit: single bytes and burst tokens.
// Depends on gmhr_pkg for the token type.
`default_nettype none

module gmhr_fifo import gmhr_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire queue_token_t push_token,
    input  wire logic         pop,
    output queue_token_t      head_token,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    queue_token_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        empty = (count_reg == '0);
        full = (count_reg == CNT_FULL);
        head_token = store_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[tb/gre_mirror_header_rewrite_unit_tb.sv]
// Self-checking testbench of gre_mirror_header_rewrite_unit: directed and random packet traffic
// against a byte-level rewrite predictor, under several idle and stall patterns.
// Depends on gmhr_pkg and the RTL of the unit only.
module gre_mirror_header_rewrite_unit_tb;
    import gmhr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    logic [11:0] tun_index;
    logic        tun_enabled;
    logic [7:0]  stamp_ttl;
    logic [15:0] stamp_proto;

    logic [POS_W-1:0] pkt_pos;
    pkt_class_t       pkt_cls;
    logic [7:0]       hdr_hold [IPV4_HDR_BYTES];
    logic [19:0]      csum_acc;

    out_item_t expected_bytes [$];
    out_item_t got_item;
    out_item_t want_item;

    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;

    gre_mirror_header_rewrite_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("gre_mirror_header_rewrite_unit_tb failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void push_expected(input logic [7:0] b, input logic lst,
                                          input logic loc, input fix_status_t st);
        out_item_t it;
        it.out_byte     = b;
        it.out_last     = lst;
        it.local_origin = lst ? loc : 1'b0;
        it.fix_status   = lst ? st : ST_REWRITTEN;
        expected_bytes.push_back(it);
    endfunction

    function automatic void predict_rewrite(input logic [11:0] ifx, input logic [7:0] d,
                                            input logic first, input logic last);
        logic [POS_W-1:0] pos;
        logic [7:0]       b;
        logic [7:0]       w;
        logic [19:0]      s;
        if (first || pkt_pos == '0) begin
            pkt_pos  = '0;
            csum_acc = '0;
            if (!tun_enabled || ifx != tun_index)
                pkt_cls = CLS_NOCFG;
            else if (d[7:4] == VER_IPV4)
                pkt_cls = CLS_V4;
            else if (d[7:4] == VER_IPV6)
                pkt_cls = CLS_V6;
            else
                pkt_cls = CLS_NOTIP;
        end
        pos = pkt_pos;
        b   = d;
        case (pkt_cls)
            CLS_NOCFG: push_expected(d, last, 1'b0, ST_NO_CFG);
            CLS_NOTIP: push_expected(d, last, 1'b0, ST_NOT_IP);
            CLS_V6: begin
                if (pos == POS_V6_HOP)
                    b = stamp_ttl;
                else if (pos == POS_V6_GRE_HI)
                    b = stamp_proto[15:8];
                else if (pos == POS_V6_GRE_LO)
                    b = stamp_proto[7:0];
                push_expected(b, last, 1'b1, ST_REWRITTEN);
            end
            default: begin
                if (pos < POS_V4_HDR_END) begin
                    w = (pos == POS_V4_TTL) ? stamp_ttl : d;
                    if (pos == POS_V4_CHK_HI || pos == POS_V4_CHK_LO)
                        w = 8'h00;
                    csum_acc = csum_acc + (pos[0] ? {12'd0, w} : {4'd0, w, 8'd0});
                    hdr_hold[pos] = d;
                    if (pos == POS_V4_HDR_LAST) begin
                        s = csum_acc;
                        s = {4'd0, s[15:0]} + {16'd0, s[19:16]};
                        s = {4'd0, s[15:0]} + {16'd0, s[19:16]};
                        s[15:0] = ~s[15:0];
                        hdr_hold[8]  = stamp_ttl;
                        hdr_hold[10] = s[15:8];
                        hdr_hold[11] = s[7:0];
                        for (int i = 0; i < IPV4_HDR_BYTES; i++)
                            push_expected(hdr_hold[i], (i == IPV4_HDR_BYTES - 1) ? last : 1'b0,
                                          1'b1, ST_REWRITTEN);
                    end else if (last) begin
                        for (int i = 0; i <= int'(pos); i++)
                            push_expected(hdr_hold[i], i == int'(pos), 1'b0, ST_NOT_IP);
                    end
                end else begin
                    if (pos == POS_V4_GRE_HI)
                        b = stamp_proto[15:8];
                    else if (pos == POS_V4_GRE_LO)
                        b = stamp_proto[7:0];
                    push_expected(b, last, 1'b1, ST_REWRITTEN);
                end
            end
        endcase
        if (last)
            pkt_pos = '0;
        else if (pkt_pos != POS_MAX)
            pkt_pos = pkt_pos + 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_item.out_byte     = m_tdata;
            got_item.out_last     = m_tlast;
            got_item.local_origin = m_tuser[0];
            got_item.fix_status   = m_tuser[2:1];
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %h last %b local %b status %0d", got_item.out_byte,
                             got_item.out_last, got_item.local_origin, got_item.fix_status);
            end else begin
                want_item = expected_bytes.pop_front();
                if (got_item !== want_item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b/%b/%0d got %h/%b/%b/%0d",
                                 want_item.out_byte, want_item.out_last,
                                 want_item.local_origin, want_item.fix_status,
                                 got_item.out_byte, got_item.out_last,
                                 got_item.local_origin, got_item.fix_status);
                end
            end
        end
    end

    task automatic send_byte(input logic [11:0] ifx, input logic [7:0] d,
                             input logic first, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, d, ifx};
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_rewrite(ifx, d, first, last);
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drained();
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (r)
            CFG_TUNNEL_INDEX:   tun_index   = v[11:0];
            CFG_TUNNEL_ENABLED: tun_enabled = v[0];
            CFG_OUTER_TTL:      stamp_ttl   = v[7:0];
            CFG_GRE_PROTO:      stamp_proto = v;
            default: ;
        endcase
    endtask

    // A negative protocol value leaves the GRE protocol register untouched.
    task automatic configure(input logic [11:0] ti, input logic en, input logic [7:0] ttl,
                             input int gre);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(CFG_TUNNEL_INDEX, {4'd0, ti});
        write_reg(CFG_TUNNEL_ENABLED, {15'd0, en});
        write_reg(CFG_OUTER_TTL, {8'd0, ttl});
        if (gre >= 0)
            write_reg(CFG_GRE_PROTO, 16'(gre));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_packet(input logic [11:0] ifx, input logic [3:0] ver, input int len,
                               input logic mark_first, input logic ends, input int stray_pct);
        logic [7:0] d;
        logic       first;
        for (int i = 0; i < len; i++) begin
            d     = (i == 0) ? {ver, 4'($urandom_range(0, 15))} : 8'($urandom_range(0, 255));
            first = (i == 0) ? mark_first : ($urandom_range(0, 99) < stray_pct);
            send_byte(ifx, d, first, ends && (i == len - 1));
        end
    endtask

    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(12'h000, 8'h45, 1'b1, 1'b1);
    endtask

    task automatic test_directed_headers();
        configure(12'hFFF, 1'b1, 8'hFF, -1);
        send_byte(12'hFFF, 8'hFF, 1'b1, 1'b1);
        send_byte(12'hFFF, 8'h4A, 1'b1, 1'b0);
        send_byte(12'hFFF, 8'hFF, 1'b0, 1'b1);
        for (int i = 0; i < IPV4_HDR_BYTES; i++)
            send_byte(12'hFFF, (i == 0) ? 8'h45 : (i[0] ? 8'hFF : 8'h00), i == 0,
                      i == IPV4_HDR_BYTES - 1);
        // IPv6 packet that starts without its first-byte marker.
        for (int i = 0; i < 8; i++)
            send_byte(12'hFFF, (i == 0) ? 8'h60 : 8'($urandom_range(0, 255)), 1'b0, i == 7);
        send_byte(12'hFFE, 8'h45, 1'b1, 1'b1);
    endtask

    task automatic test_long_packets();
        configure(12'h000, 1'b1, 8'h00, 16'hFFFF);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_packet(12'h000, VER_IPV6, 66, 1'b1, 1'b1, 0);
        pause_until_drained();
        send_packet(12'h000, VER_IPV4, 26, 1'b1, 1'b1, 0);
    endtask

    task automatic random_traffic(input int idle_pct, input int stall_pct, input int budget);
        int          sent;
        int          npkt;
        int          len;
        int          r;
        logic [11:0] ifx;
        logic [3:0]  ver;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        npkt = 0;
        ifx  = tun_index;
        while (sent < budget) begin
            ifx = ($urandom_range(0, 3) != 0) ? tun_index : 12'($urandom_range(0, 4095));
            r   = $urandom_range(0, 99);
            ver = (r < 45) ? VER_IPV4 : (r < 80) ? VER_IPV6 : 4'($urandom_range(0, 15));
            r   = $urandom_range(0, 99);
            if (r < 25)
                len = $urandom_range(1, 19);
            else if (r < 45)
                len = IPV4_HDR_BYTES;
            else if (r < 80)
                len = $urandom_range(21, 30);
            else
                len = $urandom_range(40, 50);
            send_packet(ifx, ver, len, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, 3);
            sent += len;
            npkt++;
            if (npkt == 2 || $urandom_range(0, 5) == 0)
                pause_until_drained();
        end
        // Close any packet left open so that the next register write sees an idle block.
        if (pkt_pos != '0)
            send_byte(ifx, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic test_line_rate();
        configure(12'($urandom_range(0, 4095)), 1'b1, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 65535));
        random_traffic(0, 0, 10);
    endtask

    task automatic test_sender_gaps();
        configure(12'hFFF, 1'b1, 8'h00, 16'h0000);
        random_traffic(46, 0, 10);
    endtask

    task automatic test_receiver_stalls();
        configure(12'h000, 1'b1, 8'hFF, 16'hFFFF);
        random_traffic(0, 46, 10);
    endtask

    task automatic test_both_stalls();
        configure(12'($urandom_range(0, 4095)), $urandom_range(0, 3) != 0,
                  8'($urandom_range(0, 255)), $urandom_range(0, 65535));
        random_traffic(24, 24, 10);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= 1'b0;
        s_tlast       <= 1'b0;
        m_tready      <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_TUNNEL_INDEX;
        cfg_data      <= '0;
        cycles         = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tun_index      = '0;
        tun_enabled    = 1'b0;
        stamp_ttl      = '0;
        stamp_proto    = 16'h88BE;
        pkt_pos        = '0;
        pkt_cls        = CLS_NOCFG;
        csum_acc       = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_headers();
        test_long_packets();
        test_line_rate();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_stalls();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        mismatches += expected_bytes.size();
        if (mismatches == 0) begin
            $display("gre_mirror_header_rewrite_unit_tb passed");
        end else begin
            $display("gre_mirror_header_rewrite_unit_tb failed");
        end
        $finish;
    end

endmodule
